// ----- src/etb_pkg.sv -----
// Shared types, codes and constants for the transformed ellipse bounds block.
// No dependencies; every other file imports this package.
package etb_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_TRANS  = 3'd1,
    KIND_SCALE  = 3'd2,
    KIND_SWAP   = 3'd3,
    KIND_AFFINE = 3'd4,
    KIND_DEGEN  = 3'd5
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MXX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MXY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MYX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MYY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFY = 3'd6;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_DEGEN = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] radius_x;
    logic signed [COORD_W-1:0] radius_y;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic                      status;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] hx_alt;
    logic signed [COORD_W-1:0] hy_alt;
    logic                      affine;
    logic                      degen;
  } side_t;

endpackage

// ----- src/etb_sqrt.sv -----
// Pipelined pair of integer square roots, one result bit per stage, rounded to nearest.
// Carries a side word alongside; depends on etb_pkg.
module etb_sqrt
  import etb_pkg::*;
#(
  parameter int W      = COORD_W,
  parameter int SIDE_W = $bits(side_t)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [2*W-1:0]    n_x,
  input  logic [2*W-1:0]    n_y,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_v,
  output logic [W-1:0]      root_x,
  output logic [W-1:0]      root_y,
  output logic [SIDE_W-1:0] side_out
);

  logic              v_r    [W+1];
  logic [2*W-1:0]    remx_r [W+1];
  logic [2*W-1:0]    remy_r [W+1];
  logic [W-1:0]      rtx_r  [W+1];
  logic [W-1:0]      rty_r  [W+1];
  logic [SIDE_W-1:0] side_r [W+1];

  logic              v_fin_r;
  logic [W-1:0]      rx_fin_r, ry_fin_r;
  logic [SIDE_W-1:0] side_fin_r;

  always_comb begin
    v_r[0]    = in_v;
    remx_r[0] = n_x;
    remy_r[0] = n_y;
    rtx_r[0]  = '0;
    rty_r[0]  = '0;
    side_r[0] = side_in;
  end

  for (genvar j = 0; j < W; j++) begin : g_stage
    localparam int B = W - 1 - j;
    logic [2*W-1:0] dx, dy;
    logic           takex, takey;
    always_comb begin
      dx = ((2*W)'(rtx_r[j]) << (B + 1)) | ((2*W)'(1) << (2 * B));
      dy = ((2*W)'(rty_r[j]) << (B + 1)) | ((2*W)'(1) << (2 * B));
      takex = remx_r[j] >= dx;
      takey = remy_r[j] >= dy;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[j+1] <= takex ? remx_r[j] - dx : remx_r[j];
        remy_r[j+1] <= takey ? remy_r[j] - dy : remy_r[j];
        rtx_r[j+1]  <= takex ? (rtx_r[j] | (W'(1) << B)) : rtx_r[j];
        rty_r[j+1]  <= takey ? (rty_r[j] | (W'(1) << B)) : rty_r[j];
        side_r[j+1] <= side_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_fin_r <= 1'b0;
    end else if (en) begin
      v_fin_r <= v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_fin_r   <= (remx_r[W] > (2*W)'(rtx_r[W])) ? rtx_r[W] + W'(1) : rtx_r[W];
      ry_fin_r   <= (remy_r[W] > (2*W)'(rty_r[W])) ? rty_r[W] + W'(1) : rty_r[W];
      side_fin_r <= side_r[W];
    end
  end

  assign out_v    = v_fin_r;
  assign root_x   = rx_fin_r;
  assign root_y   = ry_fin_r;
  assign side_out = side_fin_r;

endmodule

// ----- src/ellipse_transformed_bounds.sv -----
// Top level: bounding box of an axis-aligned ellipse under a configured 2D transform.
// Depends on etb_pkg and etb_sqrt.
//
//   port group   direction   handshake        contents
//   in_          input       valid / ready    one ellipse word (centre, radii)
//   out_         output      valid / ready    one box word (corners, status)
//   cfg_         input       write enable     register index and data
//
// One word is accepted every cycle while no finished word waits at the output; the
// square root pipeline resolves one root bit per stage.
// Reset clears the valid bits and loads the identity transform.
// The whole pipeline holds while a finished word waits at the output.
module ellipse_transformed_bounds
  import etb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam int W = COORD_W;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W:0] HALF = (2*W+1)'(1) << (FRAC_BITS - 1);

  function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] x);
    logic signed [W-1:0] r;
    if (x > (W+2)'(CMAX)) r = CMAX;
    else if (x < (W+2)'(CMIN)) r = CMIN;
    else r = x[W-1:0];
    return r;
  endfunction

  logic [2:0]          kind_r;
  logic signed [W-1:0] mxx_r, mxy_r, myx_r, myy_r, offx_r, offy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_IDENT;
      mxx_r  <= W'(1) << FRAC_BITS;
      mxy_r  <= '0;
      myx_r  <= '0;
      myy_r  <= W'(1) << FRAC_BITS;
      offx_r <= '0;
      offy_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KIND: kind_r <= cfg_wdata[2:0];
        CFG_MXX:  mxx_r  <= cfg_wdata;
        CFG_MXY:  mxy_r  <= cfg_wdata;
        CFG_MYX:  myx_r  <= cfg_wdata;
        CFG_MYY:  myy_r  <= cfg_wdata;
        CFG_OFFX: offx_r <= cfg_wdata;
        CFG_OFFY: offy_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  out_word_t out_word_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Stage 1: full products.
  logic                  v1_r;
  logic signed [2*W-1:0] p1_r [8];
  in_word_t              w1_r;

  logic signed [W-1:0] pa [8];
  logic signed [W-1:0] pb [8];
  always_comb begin
    pa[0] = in_word.center_x; pb[0] = mxx_r;
    pa[1] = in_word.center_y; pb[1] = myx_r;
    pa[2] = in_word.center_x; pb[2] = mxy_r;
    pa[3] = in_word.center_y; pb[3] = myy_r;
    pa[4] = in_word.radius_x; pb[4] = mxx_r;
    pa[5] = in_word.radius_y; pb[5] = myx_r;
    pa[6] = in_word.radius_x; pb[6] = mxy_r;
    pa[7] = in_word.radius_y; pb[7] = myy_r;
  end

  // Stage 2: magnitude plus rounding half. Stage 3: scale and saturate.
  logic            v2_r, v3_r;
  logic [2*W:0]    m2_r  [8];
  logic            neg2_r [8];
  logic signed [W-1:0] q3_r [8];
  in_word_t        w2_r, w3_r;

  for (genvar k = 0; k < 8; k++) begin : g_lane
    logic signed [2*W:0] pe;
    logic [2*W:0]        v3, lim3;
    logic [W-1:0]        vlo;
    always_comb begin
      pe   = (2*W+1)'(p1_r[k]);
      v3   = m2_r[k] >> FRAC_BITS;
      vlo  = v3[W-1:0];
      lim3 = (2*W+1)'(CMAX) + (2*W+1)'(neg2_r[k]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[k]   <= (2*W)'(pa[k]) * (2*W)'(pb[k]);
        neg2_r[k] <= p1_r[k] < 0;
        m2_r[k]   <= ((p1_r[k] < 0) ? $unsigned(-pe) : $unsigned(pe)) + HALF;
        if (v3 > lim3) q3_r[k] <= neg2_r[k] ? CMIN : CMAX;
        else q3_r[k] <= neg2_r[k] ? $signed(-vlo) : $signed(vlo);
      end
    end
  end

  // Stage 4: centre sums, fallback half extents and squares.
  logic                  v4_r;
  logic signed [W+1:0]   sx4_r, sy4_r;
  logic signed [W-1:0]   hx4_r, hy4_r;
  logic                  aff4_r, deg4_r;
  logic signed [2*W-1:0] sq4_r [4];

  logic signed [W-1:0] ax, bx, ox, ay, by, oy, hxa, hya;
  logic                aff, deg;
  always_comb begin
    ax = w3_r.center_x; bx = '0; ox = '0;
    ay = w3_r.center_y; by = '0; oy = '0;
    hxa = w3_r.radius_x; hya = w3_r.radius_y;
    aff = 1'b0; deg = 1'b0;
    case (kind_r)
      KIND_IDENT: ;
      KIND_TRANS: begin
        ox = offx_r; oy = offy_r;
      end
      KIND_SCALE: begin
        ax = q3_r[0]; ay = q3_r[3]; ox = offx_r; oy = offy_r;
        hxa = q3_r[4]; hya = q3_r[7];
      end
      KIND_SWAP: begin
        ax = '0; bx = q3_r[1]; ay = q3_r[2]; ox = offx_r; oy = offy_r;
        hxa = q3_r[5]; hya = q3_r[6];
      end
      KIND_AFFINE: begin
        ax = q3_r[0]; bx = q3_r[1]; ay = q3_r[2]; by = q3_r[3];
        ox = offx_r; oy = offy_r; aff = 1'b1;
      end
      default: begin
        deg = 1'b1;
      end
    endcase
  end

  // Stage 5: saturated centres and sums of squares.
  logic            v5_r;
  logic [2*W-1:0]  nx5_r, ny5_r;
  side_t           side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r  <= in_word;
      w2_r  <= w1_r;
      w3_r  <= w2_r;
      sx4_r <= (W+2)'(ax) + (W+2)'(bx) + (W+2)'(ox);
      sy4_r <= (W+2)'(ay) + (W+2)'(by) + (W+2)'(oy);
      hx4_r <= hxa;
      hy4_r <= hya;
      aff4_r <= aff;
      deg4_r <= deg;
      for (int k = 0; k < 4; k++) begin
        sq4_r[k] <= (2*W)'(q3_r[k+4]) * (2*W)'(q3_r[k+4]);
      end
      nx5_r          <= $unsigned(sq4_r[0]) + $unsigned(sq4_r[1]);
      ny5_r          <= $unsigned(sq4_r[2]) + $unsigned(sq4_r[3]);
      side5_r.tx     <= sat_w(sx4_r);
      side5_r.ty     <= sat_w(sy4_r);
      side5_r.hx_alt <= hx4_r;
      side5_r.hy_alt <= hy4_r;
      side5_r.affine <= aff4_r;
      side5_r.degen  <= deg4_r;
    end
  end

  logic              vq;
  logic [W-1:0]      rootx, rooty;
  logic [$bits(side_t)-1:0] sideq_bits;
  side_t             sideq;

  etb_sqrt #(
    .W      (W),
    .SIDE_W ($bits(side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v5_r),
    .n_x      (nx5_r),
    .n_y      (ny5_r),
    .side_in  (side5_r),
    .out_v    (vq),
    .root_x   (rootx),
    .root_y   (rooty),
    .side_out (sideq_bits)
  );

  assign sideq = side_t'(sideq_bits);

  // Edge stage: box edges, saturated.
  logic signed [W:0]   hx, hy;
  logic                ve_r, dege_r;
  logic signed [W-1:0] ax_e_r, bx_e_r, ay_e_r, by_e_r;

  always_comb begin
    hx = sideq.affine ? $signed({1'b0, rootx}) : (W+1)'(sideq.hx_alt);
    hy = sideq.affine ? $signed({1'b0, rooty}) : (W+1)'(sideq.hy_alt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ve_r        <= vq;
      out_valid_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_e_r <= sat_w((W+2)'(sideq.tx) - (W+2)'(hx));
      bx_e_r <= sat_w((W+2)'(sideq.tx) + (W+2)'(hx));
      ay_e_r <= sat_w((W+2)'(sideq.ty) - (W+2)'(hy));
      by_e_r <= sat_w((W+2)'(sideq.ty) + (W+2)'(hy));
      dege_r <= sideq.degen;
      if (dege_r) begin
        out_word_r <= '{box_min_x: '0, box_min_y: '0, box_max_x: '0, box_max_y: '0,
                        status: STATUS_DEGEN};
      end else begin
        out_word_r.box_min_x <= (ax_e_r > bx_e_r) ? bx_e_r : ax_e_r;
        out_word_r.box_max_x <= (ax_e_r > bx_e_r) ? ax_e_r : bx_e_r;
        out_word_r.box_min_y <= (ay_e_r > by_e_r) ? by_e_r : ay_e_r;
        out_word_r.box_max_y <= (ay_e_r > by_e_r) ? ay_e_r : by_e_r;
        out_word_r.status    <= STATUS_OK;
      end
    end
  end

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == STATUS_OK |->
      out_word.box_min_x <= out_word.box_max_x && out_word.box_min_y <= out_word.box_max_y)
    else $error("box corners out of order");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == STATUS_DEGEN |->
      out_word.box_min_x == '0 && out_word.box_max_x == '0 &&
      out_word.box_min_y == '0 && out_word.box_max_y == '0)
    else $error("degenerate word carries a non-zero box");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("word presented straight after reset");

endmodule

// ----- tb/sv/ellipse_transformed_bounds_test.sv -----
// Testbench for ellipse_transformed_bounds: drives ellipse words under a series of
// transform settings and checks every box word against an in-bench predictor.
// Depends on etb_pkg and the block's RTL.
`timescale 1ns / 1ps

module ellipse_transformed_bounds_test;
  import etb_pkg::*;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam int LATENCY = COORD_W + 8;
  localparam longint CYCLE_LIMIT = 2000000;

  class box_scoreboard;
    logic [2:0] kind;
    longint mxx, mxy, myx, myy, offx, offy;
    out_word_t pending_boxes[$];
    int errors;

    function new();
      errors = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      kind = KIND_IDENT;
      mxx = 65536; mxy = 0; myx = 0; myy = 65536; offx = 0; offy = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] d);
      longint v;
      v = longint'(signed'(d));
      case (idx)
        CFG_KIND: kind = d[2:0];
        CFG_MXX:  mxx = v;
        CFG_MXY:  mxy = v;
        CFG_MYX:  myx = v;
        CFG_MYY:  myy = v;
        CFG_OFFX: offx = v;
        CFG_OFFY: offy = v;
        default: ;
      endcase
    endfunction

    function longint clamp(longint x);
      if (x > CMAX) return CMAX;
      if (x < CMIN) return CMIN;
      return x;
    endfunction

    // Exact product, rounded half away from zero at the binary point, saturated.
    function longint fix_mul(longint a, longint b);
      logic signed [127:0] p;
      logic [127:0] m;
      logic [127:0] r;
      p = 128'(signed'(a)) * 128'(signed'(b));
      m = p < 0 ? -p : p;
      r = (m + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
      if (p < 0) begin
        if (r > 128'd2147483648) return CMIN;
        return -longint'(r);
      end
      if (r > 128'd2147483647) return CMAX;
      return longint'(r);
    endfunction

    function longint hypot_round(longint u, longint v);
      logic [127:0] n, c, s;
      n = 128'(u < 0 ? -u : u) * 128'(u < 0 ? -u : u)
        + 128'(v < 0 ? -v : v) * 128'(v < 0 ? -v : v);
      s = '0;
      for (int b = 49; b >= 0; b--) begin
        c = s | (128'd1 << b);
        if (c * c <= n) s = c;
      end
      if (s * s + s < n) s = s + 128'd1;
      return longint'(s);
    endfunction

    function void box_edges(longint t, longint h, output logic [31:0] lo,
                            output logic [31:0] hi);
      longint a, b, k;
      a = clamp(t - h);
      b = clamp(t + h);
      if (a > b) begin
        k = a; a = b; b = k;
      end
      lo = a[31:0];
      hi = b[31:0];
    endfunction

    function void note_ellipse(in_word_t w);
      longint cx, cy, rx, ry, tx, ty, hx, hy;
      out_word_t e;
      cx = w.center_x; cy = w.center_y; rx = w.radius_x; ry = w.radius_y;
      e = '0;
      case (kind)
        KIND_IDENT: begin
          tx = cx; ty = cy; hx = rx; hy = ry;
        end
        KIND_TRANS: begin
          tx = clamp(cx + offx); ty = clamp(cy + offy); hx = rx; hy = ry;
        end
        KIND_SCALE: begin
          tx = clamp(fix_mul(cx, mxx) + offx);
          ty = clamp(fix_mul(cy, myy) + offy);
          hx = fix_mul(rx, mxx);
          hy = fix_mul(ry, myy);
        end
        KIND_SWAP: begin
          tx = clamp(fix_mul(cy, myx) + offx);
          ty = clamp(fix_mul(cx, mxy) + offy);
          hx = fix_mul(ry, myx);
          hy = fix_mul(rx, mxy);
        end
        KIND_AFFINE: begin
          tx = clamp(fix_mul(cx, mxx) + fix_mul(cy, myx) + offx);
          ty = clamp(fix_mul(cx, mxy) + fix_mul(cy, myy) + offy);
          hx = hypot_round(fix_mul(rx, mxx), fix_mul(ry, myx));
          hy = hypot_round(fix_mul(rx, mxy), fix_mul(ry, myy));
        end
        default: begin
          e.status = STATUS_DEGEN;
          pending_boxes.push_back(e);
          return;
        end
      endcase
      box_edges(tx, hx, e.box_min_x, e.box_max_x);
      box_edges(ty, hy, e.box_min_y, e.box_max_y);
      e.status = STATUS_OK;
      pending_boxes.push_back(e);
    endfunction

    function void check_box(out_word_t got);
      out_word_t e;
      if (pending_boxes.size() == 0) begin
        $display("%0t: unexpected box word %h", $time, got);
        errors++;
        return;
      end
      e = pending_boxes.pop_front();
      if (got.box_min_x !== e.box_min_x) begin
        $display("%0t: box_min_x expected %h actual %h", $time, e.box_min_x, got.box_min_x);
        errors++;
      end
      if (got.box_min_y !== e.box_min_y) begin
        $display("%0t: box_min_y expected %h actual %h", $time, e.box_min_y, got.box_min_y);
        errors++;
      end
      if (got.box_max_x !== e.box_max_x) begin
        $display("%0t: box_max_x expected %h actual %h", $time, e.box_max_x, got.box_max_x);
        errors++;
      end
      if (got.box_max_y !== e.box_max_y) begin
        $display("%0t: box_max_y expected %h actual %h", $time, e.box_max_y, got.box_max_y);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %b actual %b", $time, e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KIND;
  logic [COORD_W-1:0] cfg_wdata = '0;

  box_scoreboard boxes = new();
  bit calm = 1'b0;
  longint cycle_count = 0;

  ellipse_transformed_bounds i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ellipse_transformed_bounds test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) boxes.check_box(out_word);
  end

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return $urandom;
      4, 5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
    endcase
  endfunction

  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    boxes.write_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic send_ellipse(logic [31:0] cx, logic [31:0] cy, logic [31:0] rx,
                              logic [31:0] ry);
    int n;
    cfg_we <= 1'b0;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 15);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{center_x: cx, center_y: cy, radius_x: rx, radius_y: ry};
    do @(posedge clk); while (!in_ready);
    boxes.note_ellipse(in_word);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (boxes.pending_boxes.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_ellipse(pick_coord(), pick_coord(), pick_coord(), pick_coord());
  endtask

  initial begin : stimulus
    logic [31:0] extremes[4];
    extremes = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset transform is identity; then every kind with extreme fields.
    for (int i = 0; i < 4; i++)
      send_ellipse(extremes[i], extremes[3 - i], extremes[(i + 1) % 4], extremes[i]);
    drain();
    write_reg(CFG_MXX, 32'h7fffffff);
    write_reg(CFG_MXY, 32'h80000000);
    write_reg(CFG_MYX, 32'h00010000);
    write_reg(CFG_MYY, 32'hffff0000);
    write_reg(CFG_OFFX, 32'h7fffffff);
    write_reg(CFG_OFFY, 32'h80000000);
    for (int k = KIND_TRANS; k <= 7; k++) begin
      write_reg(CFG_KIND, COORD_W'(k));
      send_ellipse(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
      send_ellipse(32'h00018000, 32'hfffe8000, 32'h00000001, 32'hffffffff);
      send_ellipse(32'h0, 32'h0, 32'h0, 32'h0);
      drain();
    end

    // Random transforms, each with a burst of random ellipses.
    for (int p = 0; p < 28; p++) begin
      logic [2:0] k;
      k = (p % 9 == 8) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (p == 24) calm = 1'b1;
      write_reg(CFG_KIND, COORD_W'(k));
      write_reg(CFG_MXX, pick_entry());
      write_reg(CFG_MXY, pick_entry());
      write_reg(CFG_MYX, pick_entry());
      write_reg(CFG_MYY, pick_entry());
      write_reg(CFG_OFFX, pick_coord());
      write_reg(CFG_OFFY, pick_coord());
      random_phase(50);
      drain();
    end

    if (boxes.errors == 0) begin
      $display("ellipse_transformed_bounds test passed");
    end else begin
      $display("ellipse_transformed_bounds test failed");
    end
    $finish;
  end

endmodule
